// ----- sv/afu_pkg.sv -----
// Shared types, codes, defaults and sigmoid table generation for the activation unit.
`timescale 1ns / 1ps

package afu_pkg;

   localparam int DATA_WIDTH_DEF    = 16;
   localparam int FRAC_BITS_DEF     = 12;
   localparam int TABLE_ENTRIES_DEF = 256;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FUNCTION_SELECT = 1'b0,
      CSR_DERIVATIVE_MODE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FN_SIGMOID = 2'd0,
      FN_RELU    = 2'd1,
      FN_TANH    = 2'd2,
      FN_LINEAR  = 2'd3
   } func_type;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] T_LIMIT = 64'd32 << 30;

   // Restoring long division, evaluated only while the table is elaborated.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-t) in Q30: series on t/64, then squared six times.
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t_arg);
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] sum;
      logic [63:0] term;
      t    = (t_arg > T_LIMIT) ? T_LIMIT : t_arg;
      u    = t >> 6;
      sum  = Q30_ONE;
      term = Q30_ONE;
      for (int k = 1; k <= 12; k++) begin
         term = udiv64((term * u) >> 30, 64'(k));
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int k = 0; k < 6; k++) begin
         sum = (sum * sum + (Q30_ONE >> 1)) >> 30;
      end
      return sum;
   endfunction

   // Sigmoid table point i over |x| in [0, 2^(dw-1)] raw units.
   function automatic logic [63:0] sig_point(input int i, input int dw, input int fb,
                                             input int entries);
      logic [63:0] t;
      logic [63:0] den;
      int          sh;
      sh = dw - 1 - fb;
      t  = udiv64(64'(i) << 30, 64'(entries));
      if (sh >= 0) begin
         t = t << sh;
      end else begin
         t = t >> (-sh);
      end
      if (t > T_LIMIT) begin
         t = T_LIMIT;
      end
      den = Q30_ONE + exp_neg_q30(t);
      return udiv64((64'd1 << (fb + 30)) + (den >> 1), den);
   endfunction

endpackage

// ----- sv/activation_function_unit.sv -----
// Pipelined sigmoid / ReLU / tanh / linear activation unit with derivative mode.
`timescale 1ns / 1ps

// Usage:
//   req_* : one signed fixed-point sample per transfer (DATA_WIDTH bits,
//           FRAC_BITS fraction bits) in the low bits of req_tdata.
//   rsp_* : one saturated fixed-point result per sample, in input order.
//   csr_* : write csr_wdata into register csr_index when csr_we is high.
//           Index 0 selects the function (sigmoid, relu, tanh, linear),
//           index 1 selects value (0) or derivative (1). Write only while idle.
// Throughput: one sample per cycle while the output is not stalled; the five
//   pipeline stages are table address multiply, table read, interpolation
//   multiply, interpolation sum with tanh scaling, and derivative multiply,
//   with the output register last.
// Reset: clears all valid bits, the skid stage and both registers
//   (sigmoid, value). The sigmoid table is a constant; no setup is needed.
// Stall: when rsp_tready is low the output register holds and one more result
//   drops into a skid register; req_tready then falls and the whole pipeline
//   holds until the skid entry drains. req_tready comes from a register.
module activation_function_unit #(
   parameter int DATA_WIDTH    = afu_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS     = afu_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = afu_pkg::TABLE_ENTRIES_DEF,
   localparam int TDATA_W      = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [TDATA_W-1:0]                req_tdata,   // [DATA_WIDTH-1:0] sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [TDATA_W-1:0]                rsp_tdata,   // [DATA_WIDTH-1:0] result
   input  logic                              csr_we,
   input  logic [afu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [afu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DW     = DATA_WIDTH;
   localparam int FB     = FRAC_BITS;
   localparam int N      = TABLE_ENTRIES;
   localparam int TW     = FB + 1;
   localparam int IDX_W  = $clog2(N + 1);
   localparam int POS_W  = DW + IDX_W;
   localparam int PRD_W  = TW + DW;
   localparam int SUM_W  = PRD_W + 1;
   localparam int VW     = FB + 3;
   localparam int DRV_W  = 2 * TW;
   localparam int RW     = ((DW > VW) ? DW : VW) + 2;

   localparam logic [DW-1:0]        MAX_X  = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0]        MIN_X  = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0]        SPAN_W = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [VW-1:0] ONE_V  = {{(VW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
   localparam logic signed [RW-1:0] ONE_R  = {{(RW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
   localparam logic signed [RW-1:0] MAX_R  = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [RW-1:0] MIN_R  = {{(RW-DW+1){1'b1}}, {(DW-1){1'b0}}};

   // Sigmoid table, built at elaboration.
   logic [TW-1:0] sig_tab [N+1];

   for (genvar g = 0; g <= N; g++) begin : gen_tab
      localparam logic [63:0] POINT = afu_pkg::sig_point(g, DW, FB, N);
      assign sig_tab[g] = POINT[TW-1:0];
   end

   // Configuration registers
   afu_pkg::func_type fsel_ff, fsel_in;
   logic              dmode_ff, dmode_in;

   always_comb begin
      fsel_in  = fsel_ff;
      dmode_in = dmode_ff;
      if (csr_we) begin
         unique case (csr_index)
            afu_pkg::CSR_FUNCTION_SELECT: fsel_in  = afu_pkg::func_type'(csr_wdata[1:0]);
            afu_pkg::CSR_DERIVATIVE_MODE: dmode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff  <= afu_pkg::FN_SIGMOID;
         dmode_ff <= 1'b0;
      end else begin
         fsel_ff  <= fsel_in;
         dmode_ff <= dmode_in;
      end
   end

   logic pipe_en;
   logic skid_v_ff, skid_v_in;
   logic rsp_v_ff, rsp_v_in;
   logic [DW-1:0] skid_d_ff, skid_d_in;
   logic [DW-1:0] rsp_d_ff, rsp_d_in;

   assign pipe_en    = ~skid_v_ff;
   assign req_tready = pipe_en;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // Stage 1: operand select, magnitude and table position
   logic signed [DW-1:0] req_x;
   logic signed [DW:0]   x2_s;
   logic [DW-1:0]        xs;
   logic [DW:0]          xs_e;
   logic [DW:0]          mag;
   logic [POS_W-1:0]     pos;
   logic [IDX_W-1:0]     idx1_in, idx1_ff;
   logic [DW-2:0]        frac1_in, frac1_ff;
   logic                 neg1_ff;
   logic [DW-1:0]        x1_ff;

   assign req_x = req_tdata[DW-1:0];

   always_comb begin
      x2_s = $signed({req_x, 1'b0});
      if (fsel_ff == afu_pkg::FN_TANH) begin
         if (x2_s[DW] != x2_s[DW-1]) begin
            xs = x2_s[DW] ? MIN_X : MAX_X;
         end else begin
            xs = x2_s[DW-1:0];
         end
      end else begin
         xs = req_x;
      end
      xs_e     = {xs[DW-1], xs};
      mag      = xs[DW-1] ? (~xs_e + (DW+1)'(1)) : xs_e;
      pos      = POS_W'(mag[DW-1:0]) * POS_W'(N);
      idx1_in  = pos[DW-1 +: IDX_W];
      frac1_in = pos[DW-2:0];
   end

   // Stage 2: table read of both neighbors
   logic [IDX_W-1:0] hi_idx;
   logic [TW-1:0]    tlo2_ff, thi2_ff;
   logic [DW-2:0]    frac2_ff;
   logic             neg2_ff;
   logic [DW-1:0]    x2_ff;

   assign hi_idx = (idx1_ff == IDX_W'(N)) ? idx1_ff : idx1_ff + IDX_W'(1);

   // Stage 3: interpolation products
   logic [DW-1:0]    wf;
   logic [PRD_W-1:0] p0_in, p1_in, p0_ff, p1_ff;
   logic             neg3_ff;
   logic [DW-1:0]    x3_ff;

   always_comb begin
      wf    = SPAN_W - {1'b0, frac2_ff};
      p0_in = PRD_W'(tlo2_ff) * PRD_W'(wf);
      p1_in = PRD_W'(thi2_ff) * PRD_W'(frac2_ff);
   end

   // Stage 4: round, mirror for negative input, tanh scaling
   logic [SUM_W-1:0]     isum;
   logic [TW-1:0]        yv;
   logic signed [VW-1:0] y_s, s_v, val4_in, val4_ff;
   logic [DW-1:0]        x4_ff;

   always_comb begin
      isum = SUM_W'(p0_ff) + SUM_W'(p1_ff) + (SUM_W'(1) << (DW - 2));
      yv   = isum[DW-1 +: TW];
      y_s  = $signed(VW'(yv));
      s_v  = neg3_ff ? (ONE_V - y_s) : y_s;
      if (fsel_ff == afu_pkg::FN_TANH) begin
         val4_in = (s_v <<< 1) - ONE_V;
      end else begin
         val4_in = s_v;
      end
   end

   // Stage 5: derivative product, s(1-s) or t^2
   logic signed [VW-1:0] mv, bv;
   logic [TW-1:0]        mf, bf;
   logic [DRV_W-1:0]     prod_in, prod_ff;
   logic signed [VW-1:0] val5_ff;
   logic [DW-1:0]        x5_ff;

   always_comb begin
      mv      = val4_ff[VW-1] ? -val4_ff : val4_ff;
      bv      = ONE_V - val4_ff;
      mf      = mv[TW-1:0];
      bf      = (fsel_ff == afu_pkg::FN_TANH) ? mf : bv[TW-1:0];
      prod_in = DRV_W'(mf) * DRV_W'(bf);
   end

   // Final select and saturation
   logic [DRV_W:0]       rnd_w;
   logic [TW:0]          rnd;
   logic signed [RW-1:0] rnd_r, vx_r, x_r, r_v;
   logic                 xpos;
   logic [DW-1:0]        result;

   always_comb begin
      rnd_w = (DRV_W + 1)'(prod_ff) + ((DRV_W + 1)'(1) << (FB - 1));
      rnd   = rnd_w[FB +: TW + 1];
      rnd_r = $signed(RW'(rnd));
      vx_r  = {{(RW-VW){val5_ff[VW-1]}}, val5_ff};
      x_r   = {{(RW-DW){x5_ff[DW-1]}}, x5_ff};
      xpos  = ~x5_ff[DW-1] && (x5_ff != '0);
      case (fsel_ff)
         afu_pkg::FN_SIGMOID: r_v = dmode_ff ? rnd_r : vx_r;
         afu_pkg::FN_TANH:    r_v = dmode_ff ? (ONE_R - rnd_r) : vx_r;
         afu_pkg::FN_RELU: begin
            if (xpos) begin
               r_v = dmode_ff ? ONE_R : x_r;
            end else begin
               r_v = '0;
            end
         end
         afu_pkg::FN_LINEAR:  r_v = dmode_ff ? ONE_R : x_r;
         default:             r_v = x_r;
      endcase
      if (r_v > MAX_R) begin
         result = MAX_X;
      end else if (r_v < MIN_R) begin
         result = MIN_X;
      end else begin
         result = r_v[DW-1:0];
      end
   end

   // Output register and skid stage
   always_comb begin
      rsp_v_in  = rsp_v_ff;
      rsp_d_in  = rsp_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (~rsp_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            rsp_v_in  = 1'b1;
            rsp_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            rsp_v_in = v5_ff;
            rsp_d_in = result;
         end
      end else if (v5_ff && pipe_en) begin
         // output stalled: park the stage-5 result
         skid_v_in = 1'b1;
         skid_d_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (pipe_en) begin
            v1_ff <= req_tvalid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
         end
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         idx1_ff  <= idx1_in;
         frac1_ff <= frac1_in;
         neg1_ff  <= xs[DW-1];
         x1_ff    <= req_x;
         tlo2_ff  <= sig_tab[idx1_ff];
         thi2_ff  <= sig_tab[hi_idx];
         frac2_ff <= frac1_ff;
         neg2_ff  <= neg1_ff;
         x2_ff    <= x1_ff;
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         neg3_ff  <= neg2_ff;
         x3_ff    <= x2_ff;
         val4_ff  <= val4_in;
         x4_ff    <= x3_ff;
         prod_ff  <= prod_in;
         val5_ff  <= val4_ff;
         x5_ff    <= x4_ff;
      end
      rsp_d_ff  <= rsp_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = TDATA_W'(rsp_d_ff);

   // Checks
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_v_ff)
      else $error("skid entry held while output register empty");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted sample missing from first stage");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff}))
      else $error("pipeline moved while held");

endmodule

// ----- tb/activation_function_checker.sv -----
// Checker for the activation unit: predicts each result from the sample stream and compares.
`timescale 1ns / 1ps

module activation_function_checker #(
   parameter int DATA_WIDTH    = afu_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS     = afu_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = afu_pkg::TABLE_ENTRIES_DEF,
   localparam int TDATA_W      = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [TDATA_W-1:0]              req_tdata,   // [DATA_WIDTH-1:0] sample
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [TDATA_W-1:0]              rsp_tdata,   // [DATA_WIDTH-1:0] result
   input  logic                            csr_we,
   input  logic [afu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [afu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              pending,
   output int                              errors
);

   localparam longint unsigned ONE_Q30   = 64'd1 << 30;
   localparam longint unsigned EXP_ARG_MAX = 64'd32 << 30;
   localparam longint unsigned SPAN      = 64'd1 << (DATA_WIDTH - 1);
   localparam longint          ONE_FIX   = 64'sd1 << FRAC_BITS;
   localparam longint          HALF_LSB  = 64'sd1 << (FRAC_BITS - 1);
   localparam int              ARG_SHIFT = DATA_WIDTH - 1 - FRAC_BITS;
   localparam int              MAX_PRINTS = 100;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] sample;
      logic [DATA_WIDTH-1:0] result;
   } activation_pair_type;

   longint unsigned     sigmoid_points [TABLE_ENTRIES + 1];
   activation_pair_type expected_results [$];
   afu_pkg::func_type   active_func;
   logic                derivative_on;
   int                  error_count = 0;

   assign errors = error_count;

   // exp(-t) in Q30: truncated series on t/64, then squared six times
   function automatic longint unsigned neg_exp_q30(longint unsigned t_in);
      longint unsigned t;
      longint unsigned u;
      longint unsigned acc;
      longint unsigned term;
      t    = (t_in > EXP_ARG_MAX) ? EXP_ARG_MAX : t_in;
      u    = t >> 6;
      acc  = ONE_Q30;
      term = ONE_Q30;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * u) >> 30) / longint'(k);
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      for (int k = 0; k < 6; k++) begin
         acc = (acc * acc + (ONE_Q30 >> 1)) >> 30;
      end
      return acc;
   endfunction

   function automatic void build_sigmoid_points();
      longint unsigned t;
      longint unsigned den;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         t = (longint'(i) << 30) / longint'(TABLE_ENTRIES);
         if (ARG_SHIFT >= 0) begin
            t = t << ARG_SHIFT;
         end else begin
            t = t >> (-ARG_SHIFT);
         end
         if (t > EXP_ARG_MAX) begin
            t = EXP_ARG_MAX;
         end
         den = ONE_Q30 + neg_exp_q30(t);
         sigmoid_points[i] = ((64'd1 << (FRAC_BITS + 30)) + (den >> 1)) / den;
      end
   endfunction

   // interpolate on |x|, mirror for negative x
   function automatic longint sigmoid_fixed(longint x);
      longint unsigned mag;
      longint unsigned pos;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned y;
      mag = (x < 0) ? longint'(-x) : longint'(x);
      if (mag > SPAN) begin
         mag = SPAN;
      end
      pos  = mag * TABLE_ENTRIES;
      idx  = pos >> (DATA_WIDTH - 1);
      frac = pos & (SPAN - 1);
      if (idx >= TABLE_ENTRIES) begin
         y = sigmoid_points[TABLE_ENTRIES];
      end else begin
         y = (sigmoid_points[idx] * (SPAN - frac) + sigmoid_points[idx + 1] * frac
              + (SPAN >> 1)) >> (DATA_WIDTH - 1);
      end
      return (x < 0) ? ONE_FIX - longint'(y) : longint'(y);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] predict_activation(
      logic [DATA_WIDTH-1:0] raw, afu_pkg::func_type fn, logic deriv);
      longint x;
      longint x2;
      longint s;
      longint r;
      x = longint'(signed'(raw));
      case (fn)
         afu_pkg::FN_SIGMOID: begin
            s = sigmoid_fixed(x);
            r = deriv ? (s * (ONE_FIX - s) + HALF_LSB) >>> FRAC_BITS : s;
         end
         afu_pkg::FN_RELU: begin
            if (deriv) begin
               r = (x > 0) ? ONE_FIX : 0;
            end else begin
               r = (x > 0) ? x : 0;
            end
         end
         afu_pkg::FN_TANH: begin
            // double the argument, clamped to the input range
            x2 = 2 * x;
            if (x2 > longint'(SPAN) - 1) x2 = longint'(SPAN) - 1;
            if (x2 < -longint'(SPAN)) x2 = -longint'(SPAN);
            s = 2 * sigmoid_fixed(x2) - ONE_FIX;
            if (s < 0) s = -s;
            r = deriv ? ONE_FIX - ((s * s + HALF_LSB) >>> FRAC_BITS)
                      : 2 * sigmoid_fixed(x2) - ONE_FIX;
         end
         default: begin
            r = deriv ? ONE_FIX : x;
         end
      endcase
      if (r > longint'(SPAN) - 1) r = longint'(SPAN) - 1;
      if (r < -longint'(SPAN)) r = -longint'(SPAN);
      return r[DATA_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTS) begin
         $display("%0t ns: activation check failed: %s", $time, msg);
      end
      error_count++;
   endtask

   initial begin
      build_sigmoid_points();
   end

   always @(posedge clock) begin
      activation_pair_type want;
      if (reset) begin
         active_func   = afu_pkg::FN_SIGMOID;
         derivative_on = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %h with no sample outstanding",
                                         rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[DATA_WIDTH-1:0] !== want.result) begin
                  report_mismatch($sformatf("sample %h: result %h, predicted %h",
                                            want.sample, rsp_tdata, want.result));
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               afu_pkg::CSR_FUNCTION_SELECT:
                  active_func = afu_pkg::func_type'(csr_wdata[1:0]);
               afu_pkg::CSR_DERIVATIVE_MODE: derivative_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want.sample = req_tdata[DATA_WIDTH-1:0];
            want.result = predict_activation(want.sample, active_func, derivative_on);
            expected_results.push_back(want);
         end
      end
      pending = expected_results.size();
   end

endmodule

// ----- tb/activation_function_unit_test.sv -----
// Top of the activation unit testbench: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module activation_function_unit_test;

   localparam int DW          = afu_pkg::DATA_WIDTH_DEF;
   localparam int TDATA_W     = ((DW + 7) / 8) * 8;
   localparam int PHASE_ITEMS = 250;
   localparam int CYCLE_LIMIT = 600000;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [TDATA_W-1:0]              req_tdata  = '0;   // [DW-1:0] sample
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [TDATA_W-1:0]              rsp_tdata;         // [DW-1:0] result
   logic                            csr_we     = 1'b0;
   logic [afu_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [afu_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   int                pending_results;
   int                mismatches;
   int                cycles = 0;
   bit                idle_on = 1'b1;
   afu_pkg::func_type cur_func = afu_pkg::FN_SIGMOID;
   logic              cur_deriv = 1'b0;

   activation_function_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   activation_function_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending_results),
      .errors    (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Enter and leave at a rising edge; leave right after the transfer.
   task automatic send_sample(logic [DW-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(value);
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and hold until every predicted result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   task automatic set_mode(afu_pkg::func_type fn, logic deriv);
      csr_we    <= 1'b1;
      csr_index <= afu_pkg::CSR_FUNCTION_SELECT;
      csr_wdata <= fn;
      @(posedge clock);
      // upper data bit is don't-care for the derivative register
      csr_index <= afu_pkg::CSR_DERIVATIVE_MODE;
      csr_wdata <= {1'($urandom_range(0, 1)), deriv};
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_func  = fn;
      cur_deriv = deriv;
   endtask

   task automatic run_case(afu_pkg::func_type fn, logic deriv, logic [DW-1:0] value);
      if (fn != cur_func || deriv != cur_deriv) begin
         drain();
         set_mode(fn, deriv);
      end
      send_sample(value);
   endtask

   // Result side: while idle_on is set, hold rsp_tready low for a random stall before each transfer.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 18) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      logic [DW-1:0] value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: sigmoid value, table ends and an exact table point, then sigmoid derivative
      run_case(afu_pkg::FN_SIGMOID, 1'b0, 16'h8000);
      run_case(afu_pkg::FN_SIGMOID, 1'b0, 16'h7fff);
      run_case(afu_pkg::FN_SIGMOID, 1'b0, 16'h0000);
      run_case(afu_pkg::FN_SIGMOID, 1'b0, 16'h0080);
      run_case(afu_pkg::FN_SIGMOID, 1'b0, 16'hff7f);
      run_case(afu_pkg::FN_SIGMOID, 1'b1, 16'h0000);
      run_case(afu_pkg::FN_SIGMOID, 1'b1, 16'h8000);
      // tanh: doubling clamps at both range ends
      run_case(afu_pkg::FN_TANH, 1'b0, 16'h4000);
      run_case(afu_pkg::FN_TANH, 1'b0, 16'hbfff);
      run_case(afu_pkg::FN_TANH, 1'b0, 16'h3fff);
      run_case(afu_pkg::FN_TANH, 1'b0, 16'h8000);
      run_case(afu_pkg::FN_TANH, 1'b1, 16'h0000);
      run_case(afu_pkg::FN_TANH, 1'b1, 16'h7fff);
      run_case(afu_pkg::FN_RELU, 1'b0, 16'h0001);
      run_case(afu_pkg::FN_RELU, 1'b0, 16'h0000);
      run_case(afu_pkg::FN_RELU, 1'b0, 16'hffff);
      run_case(afu_pkg::FN_RELU, 1'b0, 16'h7fff);
      run_case(afu_pkg::FN_RELU, 1'b1, 16'h0001);
      run_case(afu_pkg::FN_RELU, 1'b1, 16'h0000);
      run_case(afu_pkg::FN_RELU, 1'b1, 16'h8000);
      run_case(afu_pkg::FN_LINEAR, 1'b0, 16'h7fff);
      run_case(afu_pkg::FN_LINEAR, 1'b0, 16'h8000);
      run_case(afu_pkg::FN_LINEAR, 1'b1, 16'hfffb);

      // random phases over every function and mode, ending back at sigmoid value
      for (int f = 3; f >= 0; f--) begin
         for (int d = 1; d >= 0; d--) begin
            drain();
            set_mode(afu_pkg::func_type'(f), d[0]);
            repeat (PHASE_ITEMS) begin
               if ($urandom_range(0, 39) == 0) begin
                  idle_on = !idle_on;
               end
               case ($urandom_range(0, 3))
                  0: value = DW'($urandom);
                  1: value = DW'($urandom_range(0, 2047)) - DW'(1024);
                  2: value = $urandom_range(0, 1) ? DW'(16'h8000) + DW'($urandom_range(0, 31))
                                                  : DW'(16'h7fff) - DW'($urandom_range(0, 31));
                  default: value = (DW'($urandom_range(0, 63)) + DW'(16'h3fe0))
                                   ^ {DW{1'($urandom_range(0, 1))}};
               endcase
               send_sample(value);
            end
         end
      end

      idle_on = 1'b1;
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
